// ===== hdl/wsb_pkg.sv =====
// Shared constants for the Wilson score bound pipeline.
// No dependencies.
package wsb_pkg;

    localparam int WSB_COUNT_WIDTH    = 32;
    localparam int WSB_FRACTION_BITS  = 16;

    // quantile register, unsigned Q3.13
    localparam int          WSB_Z_WIDTH = 16;
    localparam int          WSB_Z2_WIDTH = 2 * WSB_Z_WIDTH;
    localparam logic [15:0] WSB_Z_RESET = 16'd16056;

    // fixed-point scalings of the procedure
    localparam int WSB_T_SHIFT    = 30;   // k(n-k)/n scaled by 2^30
    localparam int WSB_RAD_SHIFT  = 32;   // radicand scaled by 2^32
    localparam int WSB_BASE_SHIFT = 44;   // k term of the numerator
    localparam int WSB_Z2_SHIFT   = 17;   // 2*z^2*2^16
    localparam int WSB_DEN_SHIFT  = 28;   // n term of the denominator
    localparam int WSB_DEN_DROP   = 16;   // common factor of the denominator

endpackage

// ===== hdl/wsb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// No dependencies.
module wsb_div #(
    parameter int DW = 8,   // divisor and remainder width
    parameter int QW = 8,   // quotient bits produced
    parameter int PW = 1    // side payload width
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,    // partial remainder, below the divisor
    input  logic [QW-1:0] i_lq,     // dividend bits still to shift in
    input  logic [DW-1:0] i_div,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_lq  [QW];
    logic [DW-1:0] r_div [QW];
    logic [PW-1:0] r_pay [QW];
    logic          r_vld [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [DW-1:0] s_rem, s_div;
        logic [QW-1:0] s_lq;
        logic [PW-1:0] s_pay;
        logic          s_vld;
        logic [DW:0]   s_try;
        logic          s_ge;

        if (g == 0) begin : g_first
            assign s_rem = i_rem;
            assign s_lq  = i_lq;
            assign s_div = i_div;
            assign s_pay = i_pay;
            assign s_vld = i_valid;
        end else begin : g_next
            assign s_rem = r_rem[g-1];
            assign s_lq  = r_lq[g-1];
            assign s_div = r_div[g-1];
            assign s_pay = r_pay[g-1];
            assign s_vld = r_vld[g-1];
        end

        assign s_try = {s_rem, s_lq[QW-1]};
        assign s_ge  = s_try >= {1'b0, s_div};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= s_ge ? DW'(s_try - {1'b0, s_div}) : s_try[DW-1:0];
                r_lq[g]  <= {s_lq[QW-2:0], s_ge};
                r_div[g] <= s_div;
                r_pay[g] <= s_pay;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_lq[QW-1];
    assign o_pay   = r_pay[QW-1];

endmodule

// ===== hdl/wilson_score_bound.sv =====
// Wilson score bound: top level, a fully pipelined datapath.
// Depends on wsb_pkg and wsb_div.
//
// Takes one word (trials n, successes k, direction) per cycle and returns the
// Wilson score bound (k + z^2/2 -/+ z*sqrt(k(n-k)/n + z^2/4)) / (n + z^2) as an
// unsigned Q1.FRACTION_BITS value, rounded to nearest and clamped to 1.0.
// A zero trial count or more successes than trials returns 0 with the tuser
// error flag set. Throughput is one word per clock; the pipe is 4 front stages,
// a COUNT_WIDTH+28 stage divider for k(n-k)/n, the radicand stage, one stage
// per root bit of the square root (47 bits at the defaults), 4 middle stages,
// a FRACTION_BITS+1 stage final divider and the output register. The whole pipe
// holds while a finished word waits on m_axis_tready, so an item in flight is
// never lost or repeated. z is written through the cfg channel (always ready);
// the user writes it only while the pipe is empty; the block does not enforce it.
module wilson_score_bound
    import wsb_pkg::*;
#(
    parameter int COUNT_WIDTH   = WSB_COUNT_WIDTH,
    parameter int FRACTION_BITS = WSB_FRACTION_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [WSB_Z_WIDTH-1:0] i_cfg_data,   // z_score, Q3.13

    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // trials [CW-1:0], successes [2CW-1:CW], zero fill
    input  logic [((2*COUNT_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // mode (0 lower, 1 upper)
    input  logic                                  s_axis_tuser,

    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // bound [FB:0], zero fill
    output logic [((FRACTION_BITS+8)/8)*8-1:0]    m_axis_tdata,
    // bad_input
    output logic                                  m_axis_tuser
);

    localparam int CW  = COUNT_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int ZW  = WSB_Z_WIDTH;
    localparam int Z2W = WSB_Z2_WIDTH;
    localparam int OTW = ((FB + 8) / 8) * 8;
    // radicand high part and denominator width
    localparam int AW  = ((CW + WSB_DEN_SHIFT > Z2W + 2) ? CW + WSB_DEN_SHIFT : Z2W + 2) + 1;
    // square root width
    localparam int RW  = (AW + WSB_RAD_SHIFT + 1) / 2;
    localparam int ZRW = ZW + RW;
    // numerator width
    localparam int NW  = ((CW + WSB_BASE_SHIFT + 2 > ZRW + 1) ?
                          CW + WSB_BASE_SHIFT + 2 : ZRW + 1) + 1;
    localparam int XW  = NW + FB + 1;
    localparam int TW  = CW + WSB_DEN_SHIFT;          // quotient bits of k(n-k)/n
    localparam int H   = (CW + 1) / 2;
    localparam int PW  = 2 * CW + 2 + Z2W;            // n, k, mode, bad, z^2

    // ---------------- config register ----------------
    logic [ZW-1:0] r_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z <= WSB_Z_RESET;
        end else if (i_cfg_valid) begin
            r_z <= i_cfg_data;
        end
    end

    // ---------------- flow control ----------------
    logic r_out_vld;
    logic adv;

    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- S0: capture ----------------
    logic          r0_vld, r0_mode;
    logic [CW-1:0] r0_n, r0_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (adv) begin
            r0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_n    <= s_axis_tdata[CW-1:0];
            r0_k    <= s_axis_tdata[2*CW-1:CW];
            r0_mode <= s_axis_tuser;
        end
    end

    // ---------------- S1: n-k, z^2, input check ----------------
    logic           r1_vld, r1_mode, r1_bad;
    logic [CW-1:0]  r1_n, r1_k, r1_b;
    logic [Z2W-1:0] r1_z2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_n    <= r0_n;
            r1_k    <= r0_k;
            r1_b    <= r0_n - r0_k;
            r1_mode <= r0_mode;
            r1_bad  <= (r0_n == '0) || (r0_k > r0_n);
            r1_z2   <= r_z * r_z;
        end
    end

    // ---------------- S2: partial products of k*(n-k) ----------------
    logic               r2_vld, r2_mode, r2_bad;
    logic [CW-1:0]      r2_n, r2_k;
    logic [Z2W-1:0]     r2_z2;
    logic [2*H-1:0]     r2_p00;
    logic [CW-1:0]      r2_p01, r2_p10;
    logic [2*(CW-H)-1:0] r2_p11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_n    <= r1_n;
            r2_k    <= r1_k;
            r2_mode <= r1_mode;
            r2_bad  <= r1_bad;
            r2_z2   <= r1_z2;
            r2_p00  <= r1_k[H-1:0] * r1_b[H-1:0];
            r2_p01  <= r1_k[H-1:0] * r1_b[CW-1:H];
            r2_p10  <= r1_k[CW-1:H] * r1_b[H-1:0];
            r2_p11  <= r1_k[CW-1:H] * r1_b[CW-1:H];
        end
    end

    // ---------------- S3: product sum ----------------
    logic            r3_vld, r3_mode, r3_bad;
    logic [CW-1:0]   r3_n, r3_k;
    logic [Z2W-1:0]  r3_z2;
    logic [2*CW-1:0] r3_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (adv) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_n    <= r2_n;
            r3_k    <= r2_k;
            r3_mode <= r2_mode;
            r3_bad  <= r2_bad;
            r3_z2   <= r2_z2;
            r3_p    <= (2*CW)'(r2_p00)
                     + (((2*CW)'(r2_p01) + (2*CW)'(r2_p10)) << H)
                     + ((2*CW)'(r2_p11) << (2*H));
        end
    end

    // ---------------- T = k(n-k)*2^30 / n ----------------
    // quotient is below n*2^28, so the top bits of the dividend seed the remainder
    logic          d1_vld;
    logic [TW-1:0] d1_t;
    logic [PW-1:0] d1_pay;

    wsb_div #(.DW(CW), .QW(TW), .PW(PW)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r3_vld),
        .i_rem   (CW'(r3_p >> (CW - 2))),
        .i_lq    ({r3_p[CW-3:0], {WSB_T_SHIFT{1'b0}}}),
        .i_div   (r3_n),
        .i_pay   ({r3_n, r3_k, r3_mode, r3_bad, r3_z2}),
        .o_valid (d1_vld),
        .o_quo   (d1_t),
        .o_pay   (d1_pay)
    );

    // ---------------- S4: radicand T + 4z^2 ----------------
    logic          r4_vld;
    logic [AW-1:0] r4_rad;
    logic [PW-1:0] r4_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (adv) begin
            r4_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_rad <= AW'(d1_t) + AW'({d1_pay[Z2W-1:0], 2'b00});
            r4_pay <= d1_pay;
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    logic [RW:0]     r_sq_rem  [RW];
    logic [RW-1:0]   r_sq_root [RW];
    logic [2*RW-1:0] r_sq_rad  [RW];
    logic [PW-1:0]   r_sq_pay  [RW];
    logic            r_sq_vld  [RW];

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        logic [RW:0]     s_rem;
        logic [RW-1:0]   s_root;
        logic [2*RW-1:0] s_rad;
        logic [PW-1:0]   s_pay;
        logic            s_vld;
        logic [RW+2:0]   s_try, s_trial;
        logic            s_ge;

        if (g == 0) begin : g_first
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rad  = (2*RW)'({r4_rad, {WSB_RAD_SHIFT{1'b0}}});
            assign s_pay  = r4_pay;
            assign s_vld  = r4_vld;
        end else begin : g_next
            assign s_rem  = r_sq_rem[g-1];
            assign s_root = r_sq_root[g-1];
            assign s_rad  = r_sq_rad[g-1];
            assign s_pay  = r_sq_pay[g-1];
            assign s_vld  = r_sq_vld[g-1];
        end

        assign s_try   = {s_rem, s_rad[2*RW-1:2*RW-2]};
        assign s_trial = (RW+3)'({s_root, 2'b01});
        assign s_ge    = s_try >= s_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[g] <= 1'b0;
            end else if (adv) begin
                r_sq_vld[g] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_rem[g]  <= s_ge ? (RW+1)'(s_try - s_trial) : s_try[RW:0];
                r_sq_root[g] <= {s_root[RW-2:0], s_ge};
                r_sq_rad[g]  <= {s_rad[2*RW-3:0], 2'b00};
                r_sq_pay[g]  <= s_pay;
            end
        end
    end

    logic           sq_vld, sq_mode, sq_bad;
    logic [RW-1:0]  sq_root;
    logic [CW-1:0]  sq_n, sq_k;
    logic [Z2W-1:0] sq_z2;

    assign sq_vld  = r_sq_vld[RW-1];
    assign sq_root = r_sq_root[RW-1];
    assign {sq_n, sq_k, sq_mode, sq_bad, sq_z2} = r_sq_pay[RW-1];

    // ---------------- S5: z*R, base, denominator ----------------
    logic           r5_vld, r5_mode, r5_bad;
    logic [ZRW-1:0] r5_zr;
    logic [NW-1:0]  r5_base;
    logic [AW-1:0]  r5_den;
    logic [ZRW-1:0] zr;

    assign zr = r_z * sq_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (adv) begin
            r5_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_mode <= sq_mode;
            r5_bad  <= sq_bad;
            r5_zr   <= zr;
            r5_base <= (NW'(sq_k) << WSB_BASE_SHIFT) + (NW'(sq_z2) << WSB_Z2_SHIFT);
            r5_den  <= (AW'(sq_n) << WSB_DEN_SHIFT) + (AW'(sq_z2) << 2);
        end
    end

    // ---------------- S6: numerator ----------------
    logic          r6_vld, r6_bad;
    logic [NW-1:0] r6_num;
    logic [AW-1:0] r6_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (adv) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_bad <= r5_bad;
            r6_den <= r5_den;
            if (r5_mode) begin
                r6_num <= r5_base + NW'(r5_zr);
            end else if (r5_base < NW'(r5_zr)) begin
                r6_num <= '0;   // lower bound below zero
            end else begin
                r6_num <= r5_base - NW'(r5_zr);
            end
        end
    end

    // ---------------- S7: rounded dividend ----------------
    // den carries a factor 2^16 and is even, so it drops out of the division
    logic          r7_vld, r7_bad;
    logic [XW-1:0] r7_x;
    logic [AW-1:0] r7_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (adv) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_bad <= r6_bad;
            r7_den <= r6_den;
            r7_x   <= ((XW'(r6_num) << FB) >> WSB_DEN_DROP) + XW'(r6_den >> 1);
        end
    end

    // ---------------- S8: saturation check, divider seed ----------------
    logic          r8_vld, r8_bad, r8_sat;
    logic [AW-1:0] r8_rem, r8_den;
    logic [FB:0]   r8_lq;
    logic [XW-1:0] x_hi;

    assign x_hi = r7_x >> (FB + 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (adv) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r8_bad <= r7_bad;
            r8_den <= r7_den;
            r8_sat <= x_hi >= XW'(r7_den);
            r8_rem <= x_hi[AW-1:0];
            r8_lq  <= r7_x[FB:0];
        end
    end

    // ---------------- final divider ----------------
    logic        d2_vld, d2_sat, d2_bad;
    logic [FB:0] d2_q;

    wsb_div #(.DW(AW), .QW(FB + 1), .PW(2)) u_div_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r8_vld),
        .i_rem   (r8_rem),
        .i_lq    (r8_lq),
        .i_div   (r8_den),
        .i_pay   ({r8_sat, r8_bad}),
        .o_valid (d2_vld),
        .o_quo   (d2_q),
        .o_pay   ({d2_sat, d2_bad})
    );

    // ---------------- output register ----------------
    localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

    logic [FB:0] r_bound;
    logic        r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_bad <= d2_bad;
            if (d2_bad) begin
                r_bound <= '0;
            end else if (d2_sat || (d2_q > ONE)) begin
                r_bound <= ONE;
            end else begin
                r_bound <= d2_q;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OTW'(r_bound);
    assign m_axis_tuser  = r_bad;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for wilson_score_bound: directed table plus random words.
// Depends on wsb_pkg and the wilson_score_bound RTL; predicts each bound in 128-bit math.
module tb;
    import wsb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CW = WSB_COUNT_WIDTH;
    localparam int  FB = WSB_FRACTION_BITS;
    localparam int  QUIET_LIMIT = 4000;        // cycles with no word moving on any channel
    localparam int  DRAIN_WAIT  = 2 * CW + FB + 100;
    localparam logic DIR_LOWER = 1'b0;
    localparam logic DIR_UPPER = 1'b1;
    localparam logic [CW-1:0] CNT_MAX = '1;
    localparam logic [FB:0]   ONE_Q   = (FB + 1)'(1) << FB;

    typedef struct {
        logic [CW-1:0] trials;
        logic [CW-1:0] successes;
        logic          dir;
    } count_word_t;

    typedef struct {
        logic [FB:0] bound;
        logic        bad;
    } bound_word_t;

    // directed row: word, and a literal expectation where it is obvious
    typedef struct {
        count_word_t w;
        bit          lit;
        bound_word_t res;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [WSB_Z_WIDTH-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [2*CW-1:0] s_axis_tdata = '0;     // trials, successes
    logic s_axis_tuser = 1'b0;              // dir
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [((FB+8)/8)*8-1:0] m_axis_tdata;  // bound, zero fill
    logic m_axis_tuser;                     // bad_input

    logic [WSB_Z_WIDTH-1:0] z_now = WSB_Z_RESET;
    bound_word_t expected_bounds[$];
    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  no_idle = 1'b0;                    // stretch without gaps on either side
    int  stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    wilson_score_bound DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    // (k + z^2/2 -/+ z*sqrt(k(n-k)/n + z^2/4)) / (n + z^2), exact fixed point
    function automatic bound_word_t wilson_bound(input count_word_t w, input logic [15:0] z);
        logic [127:0] n, k, z2, t, rad, root, zr, base, num, den, q;
        bound_word_t r;
        n = w.trials;
        k = w.successes;
        z2 = z * z;
        if (n == 0 || k > n) begin
            r.bound = '0;
            r.bad = 1'b1;
            return r;
        end
        t = ((k * (n - k)) << 30) / n;
        rad = (t + 4 * z2) << 32;
        root = floor_sqrt(rad);
        zr = z * root[63:0];
        base = (k << 44) + ((2 * z2) << 16);
        if (w.dir == DIR_UPPER) num = base + zr;
        else if (base < zr) num = '0;
        else num = base - zr;
        den = ((n << 28) + 4 * z2) << 16;
        q = ((num << FB) + (den >> 1)) / den;
        if (q > ONE_Q) q = ONE_Q;
        r.bound = q[FB:0];
        r.bad = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    function automatic int idle_len();
        int p;
        if (no_idle) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Caller sits at a rising edge; returns at the edge where the word was taken.
    task automatic send_word(input count_word_t w, input bit lit, input bound_word_t res);
        int gap;
        bound_word_t exp_word;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.successes, w.trials};
        s_axis_tuser  <= w.dir;
        do @(posedge i_clk); while (!s_axis_tready);
        exp_word = lit ? res : wilson_bound(w, z_now);
        expected_bounds.insert(expected_bounds.size(), exp_word);
    endtask

    task automatic write_z(input logic [15:0] z);
        s_axis_tvalid <= 1'b0;
        while (expected_bounds.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= z;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        z_now = z;
    endtask

    function automatic count_word_t random_word();
        count_word_t w;
        int p;
        p = $urandom_range(0, 99);
        if (p < 2)       w.trials = '0;
        else if (p < 25) w.trials = $urandom_range(1, 20);
        else if (p < 50) w.trials = $urandom_range(1, 65535);
        else if (p < 92) w.trials = $urandom;
        else             w.trials = CNT_MAX - $urandom_range(0, 3);
        p = $urandom_range(0, 99);
        if (p < 84)      w.successes = $urandom_range(0, w.trials);
        else if (p < 89) w.successes = '0;
        else if (p < 94) w.successes = w.trials;
        else if (w.trials != CNT_MAX) w.successes = $urandom_range(w.trials + 1, CNT_MAX);
        else             w.successes = $urandom;
        w.dir = $urandom_range(0, 1) ? DIR_UPPER : DIR_LOWER;
        return w;
    endfunction

    // Table: bad inputs, zero successes (lower is 0), all successes (upper is 1.0),
    // count extremes and a few midpoints left to the predictor.
    dir_row_t corner_rows[] = '{
        '{'{32'd0, 32'd0, DIR_LOWER}, 1'b1, '{17'd0, 1'b1}},
        '{'{32'd0, 32'd5, DIR_UPPER}, 1'b1, '{17'd0, 1'b1}},
        '{'{32'd3, 32'd4, DIR_LOWER}, 1'b1, '{17'd0, 1'b1}},
        '{'{32'hFFFF_FFFE, 32'hFFFF_FFFF, DIR_UPPER}, 1'b1, '{17'd0, 1'b1}},
        '{'{32'd1, 32'd0, DIR_LOWER}, 1'b1, '{17'd0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'd0, DIR_LOWER}, 1'b1, '{17'd0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, DIR_UPPER}, 1'b1, '{17'h10000, 1'b0}},
        '{'{32'd1, 32'd1, DIR_UPPER}, 1'b1, '{17'h10000, 1'b0}},
        '{'{32'd1, 32'd1, DIR_LOWER}, 1'b0, '{17'd0, 1'b0}},
        '{'{32'd1, 32'd0, DIR_UPPER}, 1'b0, '{17'd0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, DIR_LOWER}, 1'b0, '{17'd0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'd0, DIR_UPPER}, 1'b0, '{17'd0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'h7FFF_FFFF, DIR_LOWER}, 1'b0, '{17'd0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'h7FFF_FFFF, DIR_UPPER}, 1'b0, '{17'd0, 1'b0}},
        '{'{32'd2, 32'd1, DIR_LOWER}, 1'b0, '{17'd0, 1'b0}},
        '{'{32'd2, 32'd1, DIR_UPPER}, 1'b0, '{17'd0, 1'b0}},
        '{'{32'd100, 32'd50, DIR_LOWER}, 1'b0, '{17'd0, 1'b0}},
        '{'{32'd1000, 32'd999, DIR_UPPER}, 1'b0, '{17'd0, 1'b0}},
        '{'{32'hAAAA_AAAA, 32'h5555_5555, DIR_LOWER}, 1'b0, '{17'd0, 1'b0}},
        '{'{32'h5555_5555, 32'h2AAA_AAAA, DIR_UPPER}, 1'b0, '{17'd0, 1'b0}}
    };

    // z settings per phase: reset value first, then extremes, 1.0 and random points
    logic [15:0] z_plan[6];

    initial begin
        z_plan = '{WSB_Z_RESET, 16'd0, 16'hFFFF, 16'd8192, 16'd0, 16'd0};
        z_plan[4] = $urandom_range(1, 65534);
        z_plan[5] = $urandom_range(1, 65534);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) write_z(z_plan[ph]);
            no_idle = (ph == 3);
            if (ph < 3)
                foreach (corner_rows[i])
                    send_word(corner_rows[i].w, corner_rows[i].lit, corner_rows[i].res);
            repeat (290) send_word(random_word(), 1'b0, '{17'd0, 1'b0});
        end
        s_axis_tvalid <= 1'b0;
        while (expected_bounds.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    // receiver back-pressure: random stalls, none started while no_idle is set
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 99) < 25) begin
            m_axis_tready <= 1'b0;
            stall_left <= idle_len();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker: every word taken on the master side against the oldest expectation
    always @(posedge i_clk) begin
        bound_word_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bounds.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata[FB:0], 0);
            end else begin
                want = expected_bounds.pop_front();
                if (m_axis_tdata[FB:0] !== want.bound)
                    report_mismatch("bound", m_axis_tdata[FB:0], want.bound);
                if (m_axis_tuser !== want.bad)
                    report_mismatch("bad_input", m_axis_tuser, want.bad);
                if (m_axis_tdata[$bits(m_axis_tdata)-1:FB+1] !== '0)
                    report_mismatch("tdata fill", m_axis_tdata, want.bound);
            end
        end
    end

    // watchdog: too long with no word moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
